### design/dik_pkg.sv
// Shared types, constants and arithmetic helpers for the delta arm solver.
package dik_pkg;

  // Config register indexes
  localparam logic [2:0] RegForearm  = 3'd0;
  localparam logic [2:0] RegBicep    = 3'd1;
  localparam logic [2:0] RegBase     = 3'd2;
  localparam logic [2:0] RegEffector = 3'd3;
  localparam logic [2:0] RegStepsA   = 3'd4;
  localparam logic [2:0] RegStepsB   = 3'd5;
  localparam logic [2:0] RegStepsC   = 3'd6;
  localparam logic [2:0] RegZHome    = 3'd7;

  // tan30/2 in Q0.32, sin120 in Q0.30
  localparam logic [30:0] EdgeK = 31'd1239850262;
  localparam logic signed [31:0] RotK = 32'sd929887697;

  localparam int SqrtSteps = 64;
  localparam int CordSteps = 30;

  localparam logic signed [33:0] HalfTurn = 34'sd2147483648;

  // atan(2^-k) in Q0.32 turns
  localparam logic [29:0] ArcTab [CordSteps] = '{
    30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
    30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
    30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722, 30'd20861,
    30'd10430, 30'd5215, 30'd2608, 30'd1304, 30'd652, 30'd326, 30'd163,
    30'd81, 30'd41, 30'd20, 30'd10, 30'd5, 30'd3, 30'd1
  };

  typedef struct packed {
    logic valid;
    logic bad;
  } ctl_t;

  // four 32x32 partial products of a 64x64 unsigned multiply
  typedef struct packed {
    logic [63:0] ll;
    logic [63:0] lh;
    logic [63:0] hl;
    logic [63:0] hh;
  } pp_t;

  function automatic pp_t pp_mul(input logic [63:0] a, input logic [63:0] b);
    pp_t p;
    p.ll = a[31:0] * b[31:0];
    p.lh = a[31:0] * b[63:32];
    p.hl = a[63:32] * b[31:0];
    p.hh = a[63:32] * b[63:32];
    return p;
  endfunction

  function automatic logic [127:0] pp_sum(input pp_t p);
    return {64'b0, p.ll} + {32'b0, p.lh, 32'b0} + {32'b0, p.hl, 32'b0} + {p.hh, 64'b0};
  endfunction

  function automatic logic [31:0] mag32(input logic signed [31:0] x);
    return x[31] ? 32'(-x) : 32'(x);
  endfunction

  function automatic logic [63:0] mag64(input logic signed [63:0] x);
    return x[63] ? 64'(-x) : 64'(x);
  endfunction

  function automatic logic [4:0] bitlen16(input logic [15:0] x);
    logic [4:0] n;
    n = '0;
    for (int i = 0; i < 16; i++) begin
      if (x[i]) n = 5'(i + 1);
    end
    return n;
  endfunction

endpackage

### design/delta_inverse_kinematics.sv
// Delta robot inverse kinematics: three rotary arms solved from one x/y/z target.
// Throughput: one word per cycle; the whole pipeline holds while a result is stalled.
// Depth is set by the 64-stage square root and the 30-stage angle CORDIC per arm.
// Reset (synchronous) clears all config registers to zero and empties the pipeline.
module delta_inverse_kinematics (
  input  logic               clk,
  input  logic               rst,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] x_pos,
  input  logic signed [31:0] y_pos,
  input  logic signed [31:0] z_pos,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] steps_arm_a,
  output logic signed [31:0] steps_arm_b,
  output logic signed [31:0] steps_arm_c,
  output logic               unreachable,
  // config write port
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam logic signed [31:0] StepMax = 32'sh7FFFFFFF;

  // ------------------------------------------------------------------
  // Config registers
  logic [30:0]        forearm_length, bicep_length, base_radius, effector_radius;
  logic [31:0]        steps_per_turn_a, steps_per_turn_b, steps_per_turn_c;
  logic signed [31:0] z_home_offset;

  always_ff @(posedge clk) begin
    if (rst) begin
      forearm_length   <= '0;
      bicep_length     <= '0;
      base_radius      <= '0;
      effector_radius  <= '0;
      steps_per_turn_a <= '0;
      steps_per_turn_b <= '0;
      steps_per_turn_c <= '0;
      z_home_offset    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dik_pkg::RegForearm:  forearm_length   <= cfg_data[30:0];
        dik_pkg::RegBicep:    bicep_length     <= cfg_data[30:0];
        dik_pkg::RegBase:     base_radius      <= cfg_data[30:0];
        dik_pkg::RegEffector: effector_radius  <= cfg_data[30:0];
        dik_pkg::RegStepsA:   steps_per_turn_a <= cfg_data;
        dik_pkg::RegStepsB:   steps_per_turn_b <= cfg_data;
        dik_pkg::RegStepsC:   steps_per_turn_c <= cfg_data;
        dik_pkg::RegZHome:    z_home_offset    <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------------
  // Geometry derived from config. Free-running; settles through d_bprod, d_base_y,
  // d_by2 and d_k0 after a write, well before the first word that uses it reaches those taps.
  logic [61:0]        d_bprod, d_eprod;
  logic [26:0]        d_rfl, d_rel;
  logic signed [31:0] d_base_y, d_eff;
  logic [53:0]        d_rf2, d_re2;
  logic signed [63:0] d_by2, d_k0;
  logic [63:0]        d_rf4;

  always_ff @(posedge clk) begin
    d_bprod  <= base_radius * dik_pkg::EdgeK;
    d_eprod  <= effector_radius * dik_pkg::EdgeK;
    d_rfl    <= bicep_length[30:4];
    d_rel    <= forearm_length[30:4];
    d_base_y <= 32'sd0 - $signed({6'b0, d_bprod[61:36]});
    d_eff    <= $signed({6'b0, d_eprod[61:36]});
    d_rf2    <= d_rfl * d_rfl;
    d_re2    <= d_rel * d_rel;
    d_by2    <= d_base_y * d_base_y;
    d_rf4    <= {8'b0, d_rf2, 2'b0};
    d_k0     <= $signed({10'b0, d_rf2}) - $signed({10'b0, d_re2}) - d_by2;
  end

  // ------------------------------------------------------------------
  // Global advance: the pipeline moves unless a finished word is held.
  logic en;

  assign in_stall = out_valid & out_stall;
  assign en       = ~in_stall;

  // T1: capture the word, add z home offset
  dik_pkg::ctl_t      t1_ctl;
  logic signed [31:0] t1_gx, t1_gy;
  logic signed [32:0] t1_z;

  always_ff @(posedge clk) begin
    if (rst) t1_ctl <= '0;
    else if (en) t1_ctl <= '{valid: in_valid, bad: 1'b0};
    if (en) begin
      t1_gx <= x_pos;
      t1_gy <= y_pos;
      t1_z  <= 33'(z_pos) + 33'(z_home_offset);
    end
  end

  // T2: Q.12 conversion, zero-height check, sin120 products
  dik_pkg::ctl_t      t2_ctl;
  logic signed [31:0] t2_gx, t2_gy, t2_ax, t2_ay, t2_zw;
  logic signed [63:0] t2_kx, t2_ky;
  logic signed [32:0] t1_zq;

  assign t1_zq = t1_z >>> 4;

  always_ff @(posedge clk) begin
    if (rst) t2_ctl <= '0;
    else if (en) t2_ctl <= '{valid: t1_ctl.valid, bad: (t1_zq == 33'sd0)};
    if (en) begin
      t2_gx <= t1_gx;
      t2_gy <= t1_gy;
      t2_ax <= t1_gx >>> 4;
      t2_ay <= t1_gy >>> 4;
      t2_zw <= 32'(t1_zq);
      t2_kx <= t1_gx * dik_pkg::RotK;
      t2_ky <= t1_gy * dik_pkg::RotK;
    end
  end

  // T3: coordinates rotated by +120 (arm B) and -120 (arm C), floored
  logic signed [63:0] t2_hx, t2_hy;
  logic signed [63:0] t2_bx, t2_by, t2_cx, t2_cy;

  always_comb begin
    t2_hx = 64'(t2_gx) <<< 29;
    t2_hy = 64'(t2_gy) <<< 29;
    t2_bx = (t2_ky - t2_hx) >>> 34;
    t2_by = (-t2_kx - t2_hy) >>> 34;
    t2_cx = (-t2_ky - t2_hx) >>> 34;
    t2_cy = (t2_kx - t2_hy) >>> 34;
  end

  dik_pkg::ctl_t      t3_ctl;
  logic signed [31:0] t3_ax, t3_ay, t3_bx, t3_by, t3_cx, t3_cy, t3_zw;

  always_ff @(posedge clk) begin
    if (rst) t3_ctl <= '0;
    else if (en) t3_ctl <= t2_ctl;
    if (en) begin
      t3_ax <= t2_ax;
      t3_ay <= t2_ay;
      t3_bx <= 32'(t2_bx);
      t3_by <= 32'(t2_by);
      t3_cx <= 32'(t2_cx);
      t3_cy <= 32'(t2_cy);
      t3_zw <= t2_zw;
    end
  end

  // ------------------------------------------------------------------
  // Three arm solvers in lockstep
  dik_pkg::ctl_t      arm_a_ctl, arm_b_ctl, arm_c_ctl;
  logic signed [31:0] arm_a_steps, arm_b_steps, arm_c_steps;

  dik_arm u_arm_a (
    .clk(clk), .rst(rst), .en(en), .ctl_in(t3_ctl),
    .px(t3_ax), .py(t3_ay), .zw(t3_zw),
    .base_y(d_base_y), .eff(d_eff), .k0(d_k0), .rf4(d_rf4),
    .spt(steps_per_turn_a), .ctl_out(arm_a_ctl), .steps(arm_a_steps)
  );

  dik_arm u_arm_b (
    .clk(clk), .rst(rst), .en(en), .ctl_in(t3_ctl),
    .px(t3_bx), .py(t3_by), .zw(t3_zw),
    .base_y(d_base_y), .eff(d_eff), .k0(d_k0), .rf4(d_rf4),
    .spt(steps_per_turn_b), .ctl_out(arm_b_ctl), .steps(arm_b_steps)
  );

  dik_arm u_arm_c (
    .clk(clk), .rst(rst), .en(en), .ctl_in(t3_ctl),
    .px(t3_cx), .py(t3_cy), .zw(t3_zw),
    .base_y(d_base_y), .eff(d_eff), .k0(d_k0), .rf4(d_rf4),
    .spt(steps_per_turn_c), .ctl_out(arm_c_ctl), .steps(arm_c_steps)
  );

  // ------------------------------------------------------------------
  // Output register: any arm without a solution, or zero height, marks
  // the whole word unreachable and pins every step count at max.
  logic bad_any;

  assign bad_any = arm_a_ctl.bad | arm_b_ctl.bad | arm_c_ctl.bad;

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= arm_a_ctl.valid & arm_b_ctl.valid & arm_c_ctl.valid;
    if (en) begin
      unreachable <= bad_any;
      steps_arm_a <= bad_any ? StepMax : arm_a_steps;
      steps_arm_b <= bad_any ? StepMax : arm_b_steps;
      steps_arm_c <= bad_any ? StepMax : arm_c_steps;
    end
  end

endmodule

### design/dik_arm.sv
// One shoulder arm: discriminant, square root, angle CORDIC and step scaling.
module dik_arm (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  dik_pkg::ctl_t       ctl_in,
  input  logic signed [31:0]  px,
  input  logic signed [31:0]  py,
  input  logic signed [31:0]  zw,
  input  logic signed [31:0]  base_y,
  input  logic signed [31:0]  eff,
  input  logic signed [63:0]  k0,
  input  logic [63:0]         rf4,
  input  logic [31:0]         spt,
  output dik_pkg::ctl_t       ctl_out,
  output logic signed [31:0]  steps
);

  // ---- A1: shifted effector y and dy
  dik_pkg::ctl_t a1_ctl;
  logic signed [31:0] a1_px, a1_pye, a1_dy, a1_zw;

  always_ff @(posedge clk) begin
    if (rst) a1_ctl <= '0;
    else if (en) a1_ctl <= ctl_in;
    if (en) begin
      a1_px  <= px;
      a1_pye <= py - eff;
      a1_dy  <= base_y - (py - eff);
      a1_zw  <= zw;
    end
  end

  // ---- A2: squares
  dik_pkg::ctl_t a2_ctl;
  logic signed [63:0] a2_px2, a2_py2, a2_z2, a2_dy2, a2_bdy;
  logic signed [31:0] a2_dy, a2_zw;

  always_ff @(posedge clk) begin
    if (rst) a2_ctl <= '0;
    else if (en) a2_ctl <= a1_ctl;
    if (en) begin
      a2_px2 <= a1_px * a1_px;
      a2_py2 <= a1_pye * a1_pye;
      a2_z2  <= a1_zw * a1_zw;
      a2_dy2 <= a1_dy * a1_dy;
      a2_bdy <= base_y * a1_dy;
      a2_dy  <= a1_dy;
      a2_zw  <= a1_zw;
    end
  end

  // ---- A3: partial sums
  dik_pkg::ctl_t a3_ctl;
  logic signed [63:0] a3_s, a3_t, a3_m;
  logic signed [31:0] a3_dy, a3_zw;

  always_ff @(posedge clk) begin
    if (rst) a3_ctl <= '0;
    else if (en) a3_ctl <= a2_ctl;
    if (en) begin
      a3_s  <= a2_px2 + a2_py2 + a2_z2 + k0;
      a3_t  <= a2_bdy <<< 1;
      a3_m  <= a2_dy2 + a2_z2;
      a3_dy <= a2_dy;
      a3_zw <= a2_zw;
    end
  end

  // ---- A4: P
  dik_pkg::ctl_t a4_ctl;
  logic signed [63:0] a4_p, a4_m;
  logic signed [31:0] a4_dy, a4_zw;

  always_ff @(posedge clk) begin
    if (rst) a4_ctl <= '0;
    else if (en) a4_ctl <= a3_ctl;
    if (en) begin
      a4_p  <= a3_s + a3_t;
      a4_m  <= a3_m;
      a4_dy <= a3_dy;
      a4_zw <= a3_zw;
    end
  end

  // ---- A5/A6: 4*rf^2*M and P^2 as partial products, then summed
  dik_pkg::ctl_t a5_ctl, a6_ctl;
  dik_pkg::pp_t a5_l, a5_r;
  logic [127:0] a6_l, a6_r;
  logic signed [63:0] a5_p, a6_p;
  logic signed [31:0] a5_dy, a5_zw, a6_dy, a6_zw;

  always_ff @(posedge clk) begin
    if (rst) begin
      a5_ctl <= '0;
      a6_ctl <= '0;
    end else if (en) begin
      a5_ctl <= a4_ctl;
      a6_ctl <= a5_ctl;
    end
    if (en) begin
      a5_l  <= dik_pkg::pp_mul(rf4, $unsigned(a4_m));
      a5_r  <= dik_pkg::pp_mul(dik_pkg::mag64(a4_p), dik_pkg::mag64(a4_p));
      a5_p  <= a4_p;
      a5_dy <= a4_dy;
      a5_zw <= a4_zw;
      a6_l  <= dik_pkg::pp_sum(a5_l);
      a6_r  <= dik_pkg::pp_sum(a5_r);
      a6_p  <= a5_p;
      a6_dy <= a5_dy;
      a6_zw <= a5_zw;
    end
  end

  // ---- A7 feeds the root pipeline at index 0
  logic [127:0]       sq_rem  [0:dik_pkg::SqrtSteps];
  logic [63:0]        sq_root [0:dik_pkg::SqrtSteps];
  logic signed [63:0] sq_p    [0:dik_pkg::SqrtSteps];
  logic signed [31:0] sq_dy   [0:dik_pkg::SqrtSteps];
  logic signed [31:0] sq_zw   [0:dik_pkg::SqrtSteps];
  dik_pkg::ctl_t      sq_ctl  [0:dik_pkg::SqrtSteps];

  always_ff @(posedge clk) begin
    if (rst) sq_ctl[0] <= '0;
    else if (en) sq_ctl[0] <= '{valid: a6_ctl.valid, bad: a6_ctl.bad | (a6_l < a6_r)};
    if (en) begin
      sq_rem[0]  <= a6_l - a6_r;
      sq_root[0] <= '0;
      sq_p[0]    <= a6_p;
      sq_dy[0]   <= a6_dy;
      sq_zw[0]   <= a6_zw;
    end
  end

  // one root bit per stage, MSB first; rem holds D - root^2
  for (genvar i = 0; i < dik_pkg::SqrtSteps; i++) begin : g_sqrt
    localparam int K = dik_pkg::SqrtSteps - 1 - i;
    logic [127:0] trial;
    logic         take;

    // root has no bits at or below K, so the two terms never overlap
    always_comb begin
      trial = ({64'b0, sq_root[i]} << (K + 1)) | (128'd1 << (2 * K));
      take  = sq_rem[i] >= trial;
    end

    always_ff @(posedge clk) begin
      if (rst) sq_ctl[i+1] <= '0;
      else if (en) sq_ctl[i+1] <= sq_ctl[i];
      if (en) begin
        sq_rem[i+1]  <= take ? sq_rem[i] - trial : sq_rem[i];
        sq_root[i+1] <= take ? (sq_root[i] | (64'd1 << K)) : sq_root[i];
        sq_p[i+1]    <= sq_p[i];
        sq_dy[i+1]   <= sq_dy[i];
        sq_zw[i+1]   <= sq_zw[i];
      end
    end
  end

  localparam int SqL = dik_pkg::SqrtSteps;

  // ---- M1: partial products of dy*P, |z|*R, dy*R, z*P
  dik_pkg::ctl_t m1_ctl;
  dik_pkg::pp_t m1_dp, m1_zr, m1_dr, m1_zp;
  logic m1_ndp, m1_ndr, m1_nzp;

  always_ff @(posedge clk) begin
    if (rst) m1_ctl <= '0;
    else if (en) m1_ctl <= sq_ctl[SqL];
    if (en) begin
      m1_dp  <= dik_pkg::pp_mul({32'b0, dik_pkg::mag32(sq_dy[SqL])},
                                dik_pkg::mag64(sq_p[SqL]));
      m1_zr  <= dik_pkg::pp_mul({32'b0, dik_pkg::mag32(sq_zw[SqL])}, sq_root[SqL]);
      m1_dr  <= dik_pkg::pp_mul({32'b0, dik_pkg::mag32(sq_dy[SqL])}, sq_root[SqL]);
      m1_zp  <= dik_pkg::pp_mul({32'b0, dik_pkg::mag32(sq_zw[SqL])},
                                dik_pkg::mag64(sq_p[SqL]));
      m1_ndp <= sq_dy[SqL][31] ^ sq_p[SqL][63];
      m1_ndr <= sq_dy[SqL][31] ^ sq_zw[SqL][31];
      // v term is -z*P
      m1_nzp <= ~(sq_zw[SqL][31] ^ sq_p[SqL][63]);
    end
  end

  // ---- M2: magnitudes
  dik_pkg::ctl_t m2_ctl;
  logic [127:0] m2_dp, m2_zr, m2_dr, m2_zp;
  logic m2_ndp, m2_ndr, m2_nzp;

  always_ff @(posedge clk) begin
    if (rst) m2_ctl <= '0;
    else if (en) m2_ctl <= m1_ctl;
    if (en) begin
      m2_dp  <= dik_pkg::pp_sum(m1_dp);
      m2_zr  <= dik_pkg::pp_sum(m1_zr);
      m2_dr  <= dik_pkg::pp_sum(m1_dr);
      m2_zp  <= dik_pkg::pp_sum(m1_zp);
      m2_ndp <= m1_ndp;
      m2_ndr <= m1_ndr;
      m2_nzp <= m1_nzp;
    end
  end

  // ---- M3: apply signs, M4: u and v
  dik_pkg::ctl_t m3_ctl, m4_ctl;
  logic [127:0] m3_dp, m3_zr, m3_dr, m3_zp;
  logic [127:0] m4_u, m4_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      m3_ctl <= '0;
      m4_ctl <= '0;
    end else if (en) begin
      m3_ctl <= m2_ctl;
      m4_ctl <= m3_ctl;
    end
    if (en) begin
      m3_dp <= m2_ndp ? -m2_dp : m2_dp;
      m3_zr <= m2_zr;
      m3_dr <= m2_ndr ? -m2_dr : m2_dr;
      m3_zp <= m2_nzp ? -m2_zp : m2_zp;
      m4_u  <= m3_dp + m3_zr;
      m4_v  <= m3_zp + m3_dr;
    end
  end

  // ---- M5: magnitudes and signs of u, v
  dik_pkg::ctl_t m5_ctl;
  logic [127:0] m5_mu, m5_mv;
  logic m5_nu, m5_nv;

  always_ff @(posedge clk) begin
    if (rst) m5_ctl <= '0;
    else if (en) m5_ctl <= m4_ctl;
    if (en) begin
      m5_nu <= m4_u[127];
      m5_nv <= m4_v[127];
      m5_mu <= m4_u[127] ? -m4_u : m4_u;
      m5_mv <= m4_v[127] ? -m4_v : m4_v;
    end
  end

  // ---- M6: per-chunk leading one of mu|mv (same length as the larger one)
  dik_pkg::ctl_t m6_ctl;
  logic [127:0] m6_mu, m6_mv;
  logic m6_nu, m6_nv;
  logic [7:0] m6_nz;
  logic [7:0][4:0] m6_pos;
  logic [127:0] m5_or;

  assign m5_or = m5_mu | m5_mv;

  always_ff @(posedge clk) begin
    if (rst) m6_ctl <= '0;
    else if (en) m6_ctl <= m5_ctl;
    if (en) begin
      m6_mu <= m5_mu;
      m6_mv <= m5_mv;
      m6_nu <= m5_nu;
      m6_nv <= m5_nv;
      for (int c = 0; c < 8; c++) begin
        m6_nz[c]  <= |m5_or[16*c +: 16];
        m6_pos[c] <= dik_pkg::bitlen16(m5_or[16*c +: 16]);
      end
    end
  end

  // ---- M7: bit length
  dik_pkg::ctl_t m7_ctl;
  logic [127:0] m7_mu, m7_mv;
  logic m7_nu, m7_nv;
  logic [7:0] m7_len;
  logic [7:0] m6_len;

  always_comb begin
    m6_len = '0;
    for (int c = 0; c < 8; c++) begin
      if (m6_nz[c]) m6_len = 8'(16 * c) + {3'b0, m6_pos[c]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) m7_ctl <= '0;
    else if (en) m7_ctl <= m6_ctl;
    if (en) begin
      m7_mu  <= m6_mu;
      m7_mv  <= m6_mv;
      m7_nu  <= m6_nu;
      m7_nv  <= m6_nv;
      m7_len <= m6_len;
    end
  end

  // ---- M8: scale both to a 30-bit magnitude, restore signs
  logic [29:0] m7_su, m7_sv;

  always_comb begin
    if (m7_len > 8'd30) begin
      m7_su = 30'(m7_mu >> (m7_len - 8'd30));
      m7_sv = 30'(m7_mv >> (m7_len - 8'd30));
    end else begin
      m7_su = 30'(m7_mu << (8'd30 - m7_len));
      m7_sv = 30'(m7_mv << (8'd30 - m7_len));
    end
  end

  dik_pkg::ctl_t m8_ctl;
  logic signed [33:0] m8_u, m8_v;

  always_ff @(posedge clk) begin
    if (rst) m8_ctl <= '0;
    else if (en) m8_ctl <= m7_ctl;
    if (en) begin
      m8_u <= m7_nu ? -$signed({4'b0, m7_su}) : $signed({4'b0, m7_su});
      m8_v <= m7_nv ? -$signed({4'b0, m7_sv}) : $signed({4'b0, m7_sv});
    end
  end

  // ---- C0: fold left half-plane, then CORDIC vectoring
  logic signed [33:0] cd_u [0:dik_pkg::CordSteps];
  logic signed [33:0] cd_v [0:dik_pkg::CordSteps];
  logic signed [33:0] cd_a [0:dik_pkg::CordSteps];
  dik_pkg::ctl_t      cd_ctl [0:dik_pkg::CordSteps];

  always_ff @(posedge clk) begin
    if (rst) cd_ctl[0] <= '0;
    else if (en) cd_ctl[0] <= m8_ctl;
    if (en) begin
      if (m8_u < 0) begin
        cd_u[0] <= -m8_u;
        cd_v[0] <= -m8_v;
        cd_a[0] <= (m8_v < 0) ? -dik_pkg::HalfTurn : dik_pkg::HalfTurn;
      end else begin
        cd_u[0] <= m8_u;
        cd_v[0] <= m8_v;
        cd_a[0] <= '0;
      end
    end
  end

  for (genvar k = 0; k < dik_pkg::CordSteps; k++) begin : g_cord
    logic signed [33:0] du, dv, arc;

    always_comb begin
      du  = cd_v[k] >>> k;
      dv  = cd_u[k] >>> k;
      arc = $signed({4'b0, dik_pkg::ArcTab[k]});
    end

    always_ff @(posedge clk) begin
      if (rst) cd_ctl[k+1] <= '0;
      else if (en) cd_ctl[k+1] <= cd_ctl[k];
      if (en) begin
        if (cd_v[k] > 0) begin
          cd_u[k+1] <= cd_u[k] + du;
          cd_v[k+1] <= cd_v[k] - dv;
          cd_a[k+1] <= cd_a[k] + arc;
        end else if (cd_v[k] < 0) begin
          cd_u[k+1] <= cd_u[k] - du;
          cd_v[k+1] <= cd_v[k] + dv;
          cd_a[k+1] <= cd_a[k] - arc;
        end else begin
          cd_u[k+1] <= cd_u[k];
          cd_v[k+1] <= cd_v[k];
          cd_a[k+1] <= cd_a[k];
        end
      end
    end
  end

  localparam int CdL = dik_pkg::CordSteps;

  // ---- S1/S2: |angle| * steps_per_turn >> 48, signed
  // |angle| < 2^33 and spt < 2^32, so the quotient fits 17 bits: no clamp needed.
  dik_pkg::ctl_t s1_ctl, s2_ctl;
  logic [33:0] s0_mag;
  logic [63:0] s1_lo;
  logic [31:0] s1_hi;
  logic        s1_neg;
  logic [64:0] s1_sum;

  assign s0_mag = cd_a[CdL][33] ? 34'(-cd_a[CdL]) : 34'(cd_a[CdL]);
  assign s1_sum = {1'b0, s1_lo} + {1'b0, s1_hi, 32'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctl <= '0;
      s2_ctl <= '0;
    end else if (en) begin
      s1_ctl <= cd_ctl[CdL];
      s2_ctl <= s1_ctl;
    end
    if (en) begin
      s1_lo  <= s0_mag[31:0] * spt;
      s1_hi  <= s0_mag[32] ? spt : '0;
      s1_neg <= cd_a[CdL][33];
      steps  <= s1_neg ? -$signed({15'b0, s1_sum[64:48]}) : $signed({15'b0, s1_sum[64:48]});
    end
  end

  assign ctl_out = s2_ctl;

endmodule
